/* hdl/aefm_pkg.sv */
// Shared constants, result selects and control/status structs for the escape frequency model.
`timescale 1ns / 1ps

package aefm_pkg;

  // Alphabet and count sizing
  localparam int MAX_SYMBOLS = 256;
  localparam int SYM_BITS    = 8;
  localparam int ASYM_BITS   = 9;
  localparam int COUNT_BITS  = 24;

  // Largest total before count updates are suppressed
  localparam logic [COUNT_BITS-1:0] TOTAL_MAX = {{(COUNT_BITS-1){1'b1}}, 1'b0};

  // Reset value of the alphabet size register
  localparam logic [ASYM_BITS-1:0] ALPHA_RESET = 9'd256;

  // Opcodes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Result selects for the output register load
  localparam logic [2:0] RES_SYM     = 3'd0;  // interval of a seen symbol
  localparam logic [2:0] RES_ESC_ENC = 3'd1;  // escape ahead of a new symbol on encode
  localparam logic [2:0] RES_PEND    = 3'd2;  // symbol decoded after an escape
  localparam logic [2:0] RES_RANK    = 3'd3;  // rank of a new symbol among unseen ones
  localparam logic [2:0] RES_ESC_DEC = 3'd4;  // escape found on decode

  // Commands from the controller
  typedef struct packed {
    logic       latch;     // capture the input transfer
    logic       prep;      // classify the item and arm the walk
    logic       walk;      // step the prefix walk
    logic       bump;      // count update
    logic       load;      // load the output register
    logic [2:0] res_sel;   // which result to load
    logic       set_pend;  // record an escape for the next decode
  } ctl_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic op;         // latched opcode
    logic sym_oor;    // encode symbol outside the alphabet
    logic pend_now;   // escape pending with unseen symbols left
    logic pend;       // item runs as a post-escape decode
    logic cum_ge_t;   // cumulative value at or above the total
    logic walk_stop;  // walk found its entry or reached its limit
    logic seen;       // walked symbol has a nonzero count
    logic out_free;   // output register can take a result
  } dp_stat_t;

endpackage

/* hdl/aefm_ctrl.sv */
// Controller state machine sequencing classify, walk, update and result loads.
`timescale 1ns / 1ps

module aefm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  aefm_pkg::dp_stat_t st,
  output aefm_pkg::ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_EMIT2 = 3'd4;
  localparam logic [2:0] S_ESC   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_sel  = aefm_pkg::RES_SYM;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (st.op == aefm_pkg::OP_ENCODE) begin
          state_nxt = st.sym_oor ? S_IDLE : S_WALK;
        end else if (st.pend_now) begin
          state_nxt = S_WALK;
        end else begin
          state_nxt = st.cum_ge_t ? S_ESC : S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (st.walk_stop) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (st.out_free) begin
          cmd.bump = 1'b1;
          cmd.load = 1'b1;
          if (st.op == aefm_pkg::OP_ENCODE) begin
            cmd.res_sel = st.seen ? aefm_pkg::RES_SYM : aefm_pkg::RES_ESC_ENC;
            state_nxt   = st.seen ? S_IDLE : S_EMIT2;
          end else begin
            cmd.res_sel = st.pend ? aefm_pkg::RES_PEND : aefm_pkg::RES_SYM;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_EMIT2: begin
        if (st.out_free) begin
          cmd.load    = 1'b1;
          cmd.res_sel = aefm_pkg::RES_RANK;
          state_nxt   = S_IDLE;
        end
      end
      S_ESC: begin
        if (st.out_free) begin
          cmd.load     = 1'b1;
          cmd.set_pend = 1'b1;
          cmd.res_sel  = aefm_pkg::RES_ESC_DEC;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/aefm_datapath.sv */
// Datapath: count memory, model state, prefix walk and output register.
`timescale 1ns / 1ps

module aefm_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // latched input fields
  input  logic                                  in_opcode,
  input  logic [aefm_pkg::SYM_BITS-1:0]         in_symbol,
  input  logic [aefm_pkg::COUNT_BITS-1:0]       in_cum,
  // configuration
  input  logic                                  cfg_we,
  input  logic [aefm_pkg::ASYM_BITS-1:0]        cfg_value,
  // controller link
  input  aefm_pkg::ctl_cmd_t                    cmd,
  output aefm_pkg::dp_stat_t                    st,
  // result register
  input  logic                                  out_take,
  output logic                                  out_valid,
  output logic [aefm_pkg::COUNT_BITS-1:0]       out_low,
  output logic [aefm_pkg::COUNT_BITS-1:0]       out_high,
  output logic [aefm_pkg::COUNT_BITS-1:0]       out_total,
  output logic [aefm_pkg::ASYM_BITS-1:0]        out_symbol,
  output logic                                  out_escape,
  output logic                                  out_last,
  output logic [aefm_pkg::COUNT_BITS-1:0]       out_next,
  output logic                                  out_full
);

  localparam int CB = aefm_pkg::COUNT_BITS;
  localparam int SB = aefm_pkg::SYM_BITS;
  localparam int AB = aefm_pkg::ASYM_BITS;

  // Count memory and its valid bits
  logic [CB-1:0]                    mem [aefm_pkg::MAX_SYMBOLS];
  logic [aefm_pkg::MAX_SYMBOLS-1:0] vld_r;
  logic [CB-1:0]                    mem_q_r;
  logic                             vq_r;
  logic                             mem_we;
  logic                             rd_en;

  // Model state
  logic [CB-1:0] total_r;
  logic [AB-1:0] distinct_r;
  logic          pending_r;
  logic [AB-1:0] alpha_r;

  // Item registers
  logic          op_r;
  logic [SB-1:0] sym_r;
  logic [CB-1:0] cum_r;
  logic [AB-1:0] unseen_r;
  logic          pend_mode_r;
  logic [SB-1:0] limit_r;
  logic [CB-1:0] acc_r;
  logic [AB-1:0] zc_r;
  logic [SB-1:0] s_r;
  logic [CB-1:0] c_r;
  logic          full_r;

  // Walk pipeline
  logic [SB-1:0] rd_idx_r;
  logic          rd_done_r;
  logic          ev_vld_r;
  logic [SB-1:0] ev_idx_r;
  logic          ev_last_r;

  // Output register
  logic          out_valid_r;
  logic [CB-1:0] o_low_r;
  logic [CB-1:0] o_high_r;
  logic [CB-1:0] o_tot_r;
  logic [AB-1:0] o_sym_r;
  logic          o_esc_r;
  logic          o_last_r;
  logic [CB-1:0] o_next_r;
  logic          o_full_r;

  // Derived values
  logic [AB-1:0] a_eff;
  logic [AB-1:0] a_m1;
  logic [AB-1:0] unseen_now;
  logic [CB-1:0] unseen_ext;
  logic [CB-1:0] zc_ext;
  logic [CB-1:0] cum_sat;
  logic [CB-1:0] cnt;
  logic [CB:0]   acc_sum;
  logic          hit_raw;
  logic          full_now;
  logic [CB-1:0] t1;
  logic [CB-1:0] tnew1;
  logic [AB-1:0] sym9;

  // Result mux
  logic [CB-1:0] r_low;
  logic [CB-1:0] r_high;
  logic [CB-1:0] r_tot;
  logic [AB-1:0] r_sym;
  logic          r_esc;
  logic          r_last;
  logic [CB-1:0] r_next;
  logic          r_full;

  // Alphabet size saturated to 1..MAX_SYMBOLS
  always_comb begin
    if (alpha_r == '0) begin
      a_eff = AB'(1);
    end else if (alpha_r > AB'(aefm_pkg::MAX_SYMBOLS)) begin
      a_eff = AB'(aefm_pkg::MAX_SYMBOLS);
    end else begin
      a_eff = alpha_r;
    end
  end

  assign a_m1       = a_eff - AB'(1);
  assign unseen_now = a_eff - distinct_r;
  assign unseen_ext = CB'(unseen_r);
  assign zc_ext     = CB'(zc_r);
  assign cum_sat    = (cum_r >= unseen_ext) ? (unseen_ext - CB'(1)) : cum_r;
  assign cnt        = vq_r ? mem_q_r : '0;
  assign acc_sum    = {1'b0, acc_r} + {1'b0, cnt};
  assign full_now   = (total_r >= aefm_pkg::TOTAL_MAX);
  assign t1         = total_r + CB'(1);
  assign tnew1      = full_now ? t1 : (total_r + CB'(2));
  assign sym9       = {1'b0, s_r};

  // Entry test for the walk, by mode
  always_comb begin
    if (op_r == aefm_pkg::OP_ENCODE) begin
      hit_raw = (ev_idx_r == sym_r);
    end else if (pend_mode_r) begin
      hit_raw = (cnt == '0) && (zc_ext == cum_sat);
    end else begin
      hit_raw = ({1'b0, cum_r} < acc_sum);
    end
  end

  // Status
  assign st.op        = op_r;
  assign st.sym_oor   = ({1'b0, sym_r} >= a_eff);
  assign st.pend_now  = pending_r && (unseen_now != '0);
  assign st.pend      = pend_mode_r;
  assign st.cum_ge_t  = (cum_r >= total_r);
  assign st.walk_stop = ev_vld_r && (hit_raw || ev_last_r);
  assign st.seen      = (c_r != '0);
  assign st.out_free  = !out_valid_r || out_take;

  assign rd_en  = cmd.walk && !rd_done_r;
  assign mem_we = cmd.bump && !full_now;

  // Result selection
  always_comb begin
    r_low  = '0;
    r_high = '0;
    r_tot  = '0;
    r_sym  = '0;
    r_esc  = 1'b0;
    r_last = 1'b1;
    r_next = '0;
    r_full = 1'b0;
    case (cmd.res_sel)
      aefm_pkg::RES_SYM: begin
        r_low  = acc_r;
        r_high = acc_r + c_r;
        r_tot  = t1;
        r_sym  = sym9;
        r_next = tnew1;
        r_full = full_now;
      end
      aefm_pkg::RES_ESC_ENC: begin
        r_low  = total_r;
        r_high = t1;
        r_tot  = t1;
        r_sym  = a_eff;
        r_esc  = 1'b1;
        r_last = 1'b0;
        r_next = unseen_ext;
        r_full = full_now;
      end
      aefm_pkg::RES_PEND: begin
        r_low  = cum_sat;
        r_high = cum_sat + CB'(1);
        r_tot  = unseen_ext;
        r_sym  = sym9;
        r_next = tnew1;
        r_full = full_now;
      end
      aefm_pkg::RES_RANK: begin
        // total already carries this item's update
        r_low  = zc_ext;
        r_high = zc_ext + CB'(1);
        r_tot  = unseen_ext;
        r_sym  = sym9;
        r_next = t1;
        r_full = full_r;
      end
      aefm_pkg::RES_ESC_DEC: begin
        r_low  = total_r;
        r_high = t1;
        r_tot  = t1;
        r_sym  = a_eff;
        r_esc  = 1'b1;
        r_next = (unseen_r != '0) ? unseen_ext : t1;
      end
      default: begin
        r_last = 1'b0;
      end
    endcase
  end

  // Count memory: at most one write per item, registered read for the walk
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s_r] <= c_r + CB'(1);
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_idx_r];
      vq_r    <= vld_r[rd_idx_r];
    end
  end

  // Control and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      total_r     <= '0;
      distinct_r  <= '0;
      pending_r   <= 1'b0;
      alpha_r     <= aefm_pkg::ALPHA_RESET;
      rd_done_r   <= 1'b0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        // register write restarts the model
        vld_r      <= '0;
        total_r    <= '0;
        distinct_r <= '0;
        pending_r  <= 1'b0;
        alpha_r    <= cfg_value;
      end else begin
        if (cmd.prep && pending_r && (unseen_now == '0)) begin
          pending_r <= 1'b0;
        end
        if (cmd.bump && pend_mode_r) begin
          pending_r <= 1'b0;
        end
        if (cmd.set_pend) begin
          pending_r <= (unseen_r != '0);
        end
        if (mem_we) begin
          vld_r[s_r] <= 1'b1;
          total_r    <= t1;
          if (c_r == '0) begin
            distinct_r <= distinct_r + AB'(1);
          end
        end
      end

      // walk issue and evaluate flags
      if (cmd.prep) begin
        rd_done_r <= 1'b0;
        ev_vld_r  <= 1'b0;
      end else if (cmd.walk) begin
        ev_vld_r <= !rd_done_r;
        if (!rd_done_r) begin
          rd_done_r <= (rd_idx_r == limit_r);
        end
      end

      // output register
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_opcode;
      sym_r <= in_symbol;
      cum_r <= in_cum;
    end
    if (cmd.prep) begin
      unseen_r    <= unseen_now;
      pend_mode_r <= (op_r == aefm_pkg::OP_DECODE) && st.pend_now;
      limit_r     <= (op_r == aefm_pkg::OP_DECODE) ? a_m1[SB-1:0] : sym_r;
      acc_r       <= '0;
      zc_r        <= '0;
      rd_idx_r    <= '0;
      s_r         <= a_m1[SB-1:0];
      c_r         <= '0;
    end
    if (rd_en) begin
      ev_idx_r  <= rd_idx_r;
      ev_last_r <= (rd_idx_r == limit_r);
      rd_idx_r  <= rd_idx_r + SB'(1);
    end
    // evaluate the entry read last cycle
    if (cmd.walk && ev_vld_r) begin
      if (hit_raw) begin
        s_r <= ev_idx_r;
        c_r <= cnt;
      end else if (!ev_last_r) begin
        acc_r <= acc_sum[CB-1:0];
        if (cnt == '0) begin
          zc_r <= zc_r + AB'(1);
        end
      end
    end
    if (cmd.bump) begin
      full_r <= full_now;
    end
    if (cmd.load) begin
      o_low_r  <= r_low;
      o_high_r <= r_high;
      o_tot_r  <= r_tot;
      o_sym_r  <= r_sym;
      o_esc_r  <= r_esc;
      o_last_r <= r_last;
      o_next_r <= r_next;
      o_full_r <= r_full;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_low    = o_low_r;
  assign out_high   = o_high_r;
  assign out_total  = o_tot_r;
  assign out_symbol = o_sym_r;
  assign out_escape = o_esc_r;
  assign out_last   = o_last_r;
  assign out_next   = o_next_r;
  assign out_full   = o_full_r;

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_take))
    else $error("result loaded over an untaken result");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && !cfg_we) |=> (total_r == $past(total_r) + CB'(1)))
    else $error("total did not advance by one on update");

  a_distinct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    distinct_r <= a_eff)
    else $error("distinct count exceeds alphabet size");

  a_walk_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk && ev_vld_r) |-> (ev_idx_r <= limit_r))
    else $error("walk evaluated an entry past its limit");

endmodule

/* hdl/adaptive_escape_frequency_model.sv */
// Top level of the adaptive escape frequency model: stream ports, controller and datapath.
// Each item walks the count memory one entry per cycle; encode walks up to its symbol and
// decode up to the last symbol of the alphabet before the first result; an escape decode that
// needs no walk goes from classify straight to its result. A new symbol on encode has a
// second result after the first. One item at a time: the next is taken once this one is done.
// Reset (rst_n low, synchronous) or a configuration write clears all counts at once.
`timescale 1ns / 1ps

module adaptive_escape_frequency_model (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // symbol[7:0], cum_count[31:8]
  input  logic [0:0]   in_tuser,   // opcode[0]
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // range_low[23:0], range_high[47:24], range_total[71:48],
                                   // decoded_symbol[80:72], next_total[104:81],
                                   // count_full[105], zero[111:106]
  output logic [0:0]   out_tuser,  // is_escape[0]
  output logic         out_tlast,
  // configuration write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [8:0]   cfg_data    // alphabet_size
);

  aefm_pkg::ctl_cmd_t cmd;
  aefm_pkg::dp_stat_t st;

  logic [aefm_pkg::COUNT_BITS-1:0] o_low;
  logic [aefm_pkg::COUNT_BITS-1:0] o_high;
  logic [aefm_pkg::COUNT_BITS-1:0] o_tot;
  logic [aefm_pkg::ASYM_BITS-1:0]  o_sym;
  logic                            o_esc;
  logic                            o_last;
  logic [aefm_pkg::COUNT_BITS-1:0] o_next;
  logic                            o_full;
  logic                            o_valid;

  // Configuration is taken on any cycle
  assign cfg_ready = 1'b1;

  aefm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  aefm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_opcode  (in_tuser[0]),
    .in_symbol  (in_tdata[7:0]),
    .in_cum     (in_tdata[31:8]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_value  (cfg_data),
    .cmd        (cmd),
    .st         (st),
    .out_take   (out_tready),
    .out_valid  (o_valid),
    .out_low    (o_low),
    .out_high   (o_high),
    .out_total  (o_tot),
    .out_symbol (o_sym),
    .out_escape (o_esc),
    .out_last   (o_last),
    .out_next   (o_next),
    .out_full   (o_full)
  );

  // Result packing
  assign out_tvalid = o_valid;
  assign out_tdata  = {6'b0, o_full, o_next, o_sym, o_tot, o_high, o_low};
  assign out_tuser  = o_esc;
  assign out_tlast  = o_last;

endmodule

/* bench/tb_adaptive_escape_frequency_model.sv */
// Self-checking bench for the adaptive escape frequency model: scoreboard class, stream drivers.
`timescale 1ns / 1ps

// One result beat as it leaves the block
typedef struct packed {
  logic [23:0] range_low;
  logic [23:0] range_high;
  logic [23:0] range_total;
  logic [8:0]  decoded_symbol;
  logic        is_escape;
  logic        last;
  logic [23:0] next_total;
  logic        count_full;
} interval_t;

// Frequency-model predictor plus the queue of intervals still owed by the block
class freq_scoreboard;
  int unsigned sym_count [aefm_pkg::MAX_SYMBOLS];
  int unsigned total;
  int unsigned distinct;
  bit          esc_pending;
  logic [8:0]  alpha_reg;
  interval_t   due_q[$];
  int          errors;

  function new();
    alpha_reg = aefm_pkg::ALPHA_RESET;
    errors    = 0;
    clear_counts();
  endfunction

  function void clear_counts();
    foreach (sym_count[i]) sym_count[i] = 0;
    total       = 0;
    distinct    = 0;
    esc_pending = 1'b0;
  endfunction

  // A register write also wipes the model
  function void set_alphabet(logic [8:0] v);
    alpha_reg = v;
    clear_counts();
  endfunction

  // Alphabet in use, saturated to 1..MAX_SYMBOLS
  function int unsigned alphabet();
    if (alpha_reg == 9'd0) return 1;
    if (32'(alpha_reg) > aefm_pkg::MAX_SYMBOLS) return aefm_pkg::MAX_SYMBOLS;
    return 32'(alpha_reg);
  endfunction

  function int unsigned unseen();
    return alphabet() - distinct;
  endfunction

  // Count update; returns 1 when suppressed because the total is saturated
  function bit bump_count(int unsigned s);
    if (total >= 32'(aefm_pkg::TOTAL_MAX)) return 1'b1;
    if (sym_count[s] == 0) distinct++;
    sym_count[s]++;
    total++;
    return 1'b0;
  endfunction

  function void add_due(int unsigned lo, int unsigned hi, int unsigned tot, int unsigned sym,
                        bit esc, bit lst, int unsigned nxt, bit full);
    interval_t r;
    r.range_low      = 24'(lo);
    r.range_high     = 24'(hi);
    r.range_total    = 24'(tot);
    r.decoded_symbol = 9'(sym);
    r.is_escape      = esc;
    r.last           = lst;
    r.next_total     = 24'(nxt);
    r.count_full     = full;
    due_q.push_back(r);
  endfunction

  // Accepted input transfer: advance the model and queue the intervals it causes
  function void note_input(logic op, logic [7:0] sym, logic [23:0] cum);
    int unsigned a, free_n, s, acc, c, t, cv, rank, nxt;
    bit          full, found;
    a      = alphabet();
    free_n = a - distinct;
    acc    = 0;
    t      = total;
    if (op == aefm_pkg::OP_ENCODE) begin
      s = 32'(sym);
      // symbol outside the alphabet is dropped silently
      if (s >= a) return;
      c = sym_count[s];
      if (c != 0) begin
        for (int i = 0; i < s; i++) acc += sym_count[i];
        full = bump_count(s);
        add_due(acc, acc + c, t + 1, s, 1'b0, 1'b1, total + 1, full);
      end else begin
        // new symbol: escape first, then its rank among the unseen ones
        for (int i = 0; i < s; i++) if (sym_count[i] == 0) acc++;
        full = bump_count(s);
        add_due(t, t + 1, t + 1, a, 1'b1, 1'b0, free_n, full);
        add_due(acc, acc + 1, free_n, s, 1'b0, 1'b1, total + 1, full);
      end
      return;
    end

    cv = 32'(cum);
    // pending escape with nothing left unseen falls back to an ordinary decode
    if (esc_pending && free_n == 0) esc_pending = 1'b0;
    if (esc_pending) begin
      if (cv >= free_n) cv = free_n - 1;
      s    = a - 1;
      rank = 0;
      for (int i = 0; i < a; i++) begin
        if (sym_count[i] == 0) begin
          if (rank == cv) begin
            s = i;
            break;
          end
          rank++;
        end
      end
      esc_pending = 1'b0;
      full = bump_count(s);
      add_due(cv, cv + 1, free_n, s, 1'b0, 1'b1, total + 1, full);
      return;
    end

    found = 1'b0;
    s     = 0;
    if (cv < t) begin
      for (int i = 0; i < a; i++) begin
        if (cv < acc + sym_count[i]) begin
          s     = i;
          found = 1'b1;
          break;
        end
        acc += sym_count[i];
      end
    end
    if (!found) begin
      // escape slot; arm the post-escape search only if something is unseen
      nxt = t + 1;
      if (free_n > 0) begin
        esc_pending = 1'b1;
        nxt         = free_n;
      end
      add_due(t, t + 1, t + 1, a, 1'b1, 1'b1, nxt, 1'b0);
      return;
    end
    c    = sym_count[s];
    full = bump_count(s);
    add_due(acc, acc + c, t + 1, s, 1'b0, 1'b1, total + 1, full);
  endfunction

  function void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Accepted result transfer: compare against the oldest owed interval
  function void check_result(interval_t got);
    interval_t want;
    if (due_q.size() == 0) begin
      if (errors < 40) $error("result transfer with nothing outstanding (low %0d)", got.range_low);
      errors++;
      return;
    end
    want = due_q.pop_front();
    cmp_field("range_low",      32'(want.range_low),      32'(got.range_low));
    cmp_field("range_high",     32'(want.range_high),     32'(got.range_high));
    cmp_field("range_total",    32'(want.range_total),    32'(got.range_total));
    cmp_field("decoded_symbol", 32'(want.decoded_symbol), 32'(got.decoded_symbol));
    cmp_field("is_escape",      32'(want.is_escape),      32'(got.is_escape));
    cmp_field("last",           32'(want.last),           32'(got.last));
    cmp_field("next_total",     32'(want.next_total),     32'(got.next_total));
    cmp_field("count_full",     32'(want.count_full),     32'(got.count_full));
  endfunction
endclass

module tb_adaptive_escape_frequency_model;

  localparam int SETTLE_CYCLES  = 300;    // longer than the walk of one item, covers a silent dropped item
  localparam int LONG_HOLD      = 3000;   // receiver back-pressure stretch
  localparam int WATCHDOG_LIMIT = 20000;  // several times the longest legal quiet stretch

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;   // symbol[7:0], cum_count[31:8]
  logic [0:0]   in_tuser;   // opcode[0]
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;  // range_low, range_high, range_total, decoded_symbol,
                            // next_total, count_full, zero pad
  logic [0:0]   out_tuser;  // is_escape[0]
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [8:0]   cfg_data;   // alphabet_size

  freq_scoreboard sb = new();
  int             burst_left = 0;
  bit             sending = 1'b0;
  int             out_seen = 0;
  bit             long_hold_done = 1'b0;
  int             quiet_cycles = 0;

  adaptive_escape_frequency_model DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one item, wait for its transfer, then maybe open a gap before the next burst
  task automatic feed(logic op, logic [7:0] sym, logic [23:0] cum);
    int gap;
    in_tuser  <= op;
    in_tdata  <= {cum, sym};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, sym, cum);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(20, 300);
        default: gap = $urandom_range(1, 15);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_cfg(logic [8:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_alphabet(v);
  endtask

  // Stop offering, let every owed interval drain, then give the walk time to finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    sending = 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic: mostly coherent encode/decode use, some out-of-range and wild values
  task automatic run_random(int n);
    int          done_n;
    int unsigned a, r, fr;
    logic        op;
    logic [7:0]  sym;
    logic [23:0] cum;
    done_n  = 0;
    sending = 1'b1;
    while (done_n < n) begin
      a   = sb.alphabet();
      fr  = sb.unseen();
      r   = $urandom_range(0, 99);
      sym = 8'($urandom);
      cum = 24'($urandom);
      if (sb.esc_pending ? (r < 80) : (r < 50)) op = aefm_pkg::OP_DECODE;
      else op = aefm_pkg::OP_ENCODE;
      r = $urandom_range(0, 99);
      if (op == aefm_pkg::OP_ENCODE) begin
        if (r < 45) sym = 8'($urandom_range(0, (a < 8) ? a - 1 : 7));
        else if (r < 92) sym = 8'($urandom_range(0, a - 1));
        if (32'(sym) < a) done_n++;
      end else begin
        if (sb.esc_pending && fr > 0) begin
          if (r < 75) cum = 24'($urandom_range(0, fr - 1));
        end else if (r < 70) begin
          cum = 24'($urandom_range(0, sb.total));
        end else if (r < 80) begin
          cum = 24'(sb.total);
        end
        done_n++;
      end
      feed(op, sym, cum);
    end
  endtask

  // Result monitor
  always @(posedge clk) begin : result_mon
    interval_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.range_low      = out_tdata[23:0];
      got.range_high     = out_tdata[47:24];
      got.range_total    = out_tdata[71:48];
      got.decoded_symbol = out_tdata[80:72];
      got.next_total     = out_tdata[104:81];
      got.count_full     = out_tdata[105];
      got.is_escape      = out_tuser[0];
      got.last           = out_tlast;
      sb.check_result(got);
      out_seen++;
    end
  end

  // Receiver: random stall pattern, plus one long hold-off while the sender keeps offering
  initial begin
    rx_mode_t mode;
    int       span;
    mode = RX_OPEN;
    span = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && sending && out_seen >= 120) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          span = $urandom_range(20, 400);
        end
        span--;
        case (mode)
          RX_OPEN:  out_tready <= 1'b1;
          RX_COIN:  out_tready <= 1'($urandom & 1);
          default:  out_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** adaptive_escape_frequency_model: FAILED **");
      $finish;
    end
  end

  // Main sequence
  initial begin
    logic [8:0] alpha_plan [9];
    alpha_plan = '{9'd0, 9'd1, 9'd2, 9'd511, 9'd3, 9'd17, 9'd0, 9'd256, 9'd257};
    alpha_plan[6] = 9'($urandom_range(4, 255));
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, full alphabet from reset
    sending = 1'b1;
    feed(aefm_pkg::OP_ENCODE, 8'd255, 24'($urandom));   // new symbol at the top of the alphabet
    feed(aefm_pkg::OP_ENCODE, 8'd0,   24'($urandom));   // new symbol at the bottom
    feed(aefm_pkg::OP_ENCODE, 8'd255, 24'($urandom));   // seen symbol
    feed(aefm_pkg::OP_DECODE, 8'($urandom), 24'd0);
    feed(aefm_pkg::OP_DECODE, 8'($urandom), 24'd2);
    feed(aefm_pkg::OP_DECODE, 8'($urandom), 24'hFFFFFF); // beyond the total: escape, arms pending
    feed(aefm_pkg::OP_DECODE, 8'($urandom), 24'hFFFFFF); // pending rank saturates to last unseen
    feed(aefm_pkg::OP_DECODE, 8'($urandom), 24'd0);
    feed(aefm_pkg::OP_DECODE, 8'($urandom), 24'd4);      // below the total: ordinary decode
    feed(aefm_pkg::OP_ENCODE, 8'd7,   24'($urandom));   // new symbol between decodes: escape, then rank
    feed(aefm_pkg::OP_DECODE, 8'($urandom), 24'd0);      // ordinary decode at the bottom of the range
    wait_idle();

    // Directed, two-symbol alphabet: exhausting the unseen set
    write_cfg(9'd2);
    sending = 1'b1;
    feed(aefm_pkg::OP_DECODE, 8'($urandom), 24'd0);      // empty model: escape
    feed(aefm_pkg::OP_ENCODE, 8'd200, 24'($urandom));   // outside the alphabet, dropped
    feed(aefm_pkg::OP_ENCODE, 8'd1,   24'($urandom));
    feed(aefm_pkg::OP_ENCODE, 8'd0,   24'($urandom));   // nothing unseen now
    feed(aefm_pkg::OP_DECODE, 8'($urandom), 24'd0);      // stale pending dropped, ordinary decode
    feed(aefm_pkg::OP_DECODE, 8'($urandom), 24'hFFFFFF); // escape with nothing unseen
    feed(aefm_pkg::OP_DECODE, 8'($urandom), 24'd1);
    feed(aefm_pkg::OP_ENCODE, 8'd1,   24'($urandom));
    wait_idle();

    // Random phases across alphabet settings, saturating values among them
    foreach (alpha_plan[k]) begin
      write_cfg(alpha_plan[k]);
      run_random(83);
      wait_idle();
    end

    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("** adaptive_escape_frequency_model: PASSED **");
    end else begin
      $display("** adaptive_escape_frequency_model: FAILED **");
    end
    $finish;
  end

endmodule
